[rtl/shuffled_lehmer_uniform_generator_unit_macros.svh]
// Assertion macros for the shuffled Lehmer generator.
// Expects signals named clock and reset in the scope of use; no other dependencies.
`ifndef SHUFFLED_LEHMER_UNIFORM_GENERATOR_UNIT_MACROS_SVH
`define SHUFFLED_LEHMER_UNIFORM_GENERATOR_UNIT_MACROS_SVH

// Same-cycle implication, checked at every rising edge outside reset.
`define SLUG_ASSERT_NOW(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |-> (cons)) \
      else $error(msg);

// Next-cycle implication.
`define SLUG_ASSERT_NEXT(lbl, ante, cons, msg) \
   lbl: assert property (@(posedge clock) disable iff (reset) (ante) |=> (cons)) \
      else $error(msg);

`endif

[rtl/slug_pkg.sv]
// Shared types and fixed constants of the shuffled Lehmer generator.
// No dependencies; the top level imports it.
package slug_pkg;

   localparam int WORD_W      = 31;
   localparam int MUL_W       = 15;
   localparam int PROD_W      = WORD_W + MUL_W;
   localparam int REQ_TDATA_W = 32;
   localparam int RSP_TDATA_W = 64;
   localparam int WARMUP_EXTRA = 8;

   typedef logic [WORD_W-1:0] word_type;

   localparam word_type            LEH_MOD = 31'h7FFF_FFFF;
   localparam logic [MUL_W-1:0]    LEH_MUL = 15'd16807;

   // Command carried on req_tuser; the other value requests a plain draw.
   localparam logic CMD_RESEED = 1'b1;

endpackage

[rtl/shuffled_lehmer_uniform_generator_unit.sv]
// Shuffled Lehmer uniform generator, single-module implementation.
// Depends on slug_pkg and shuffled_lehmer_uniform_generator_unit_macros.svh.
//
// Minimal-standard Lehmer generator (x -> 16807 x mod 2^31-1) behind a
// Bays-Durham shuffle table of TABLE_SIZE entries. Each request word is either a
// draw (req_tuser = 0) or a reseed followed by a draw (req_tuser = 1, seed in
// req_tdata); a seed of zero or of 2^31-1 is taken as 1, and a draw before any
// seed seeds with 1. Every request returns exactly one response word holding the
// shuffled output and the new generator state; the uniform real value is
// random_value / 2147483647. One shared 31x15 multiplier with a Mersenne-modulus
// fold performs every generator step (multiply, then fold). A plain draw passes
// through the states accept, multiply, fold with table read-modify-write, and
// response load, which waits until the response register is free. A reseed,
// or the first draw after reset, adds TABLE_SIZE + 8 warm-up steps, each a
// multiply and a fold. req_tready is high only while the
// sequencer is idle; the response register lets a new request be accepted while
// the previous response still waits, and the sequencer holds its result until
// the response register is free. Table contents are never read before a seeding
// pass has written every entry, so the table needs no clearing after reset.
module shuffled_lehmer_uniform_generator_unit #(
   parameter int TABLE_SIZE = 32
) (
   input  logic                              clock,
   input  logic                              reset,
   // request channel
   input  logic                              req_tvalid,
   output logic                              req_tready,
   input  logic [slug_pkg::REQ_TDATA_W-1:0]  req_tdata,  // [30:0] seed, [31] zero
   input  logic                              req_tuser,  // [0] command
   // response channel
   output logic                              rsp_tvalid,
   input  logic                              rsp_tready,
   output logic [slug_pkg::RSP_TDATA_W-1:0]  rsp_tdata   // [30:0] random_value,
                                                         // [61:31] next_seed,
                                                         // [63:62] zero
);
   import slug_pkg::*;

   localparam int SW     = (TABLE_SIZE > 1) ? $clog2(TABLE_SIZE) : 1;
   localparam int WARMUP = TABLE_SIZE + WARMUP_EXTRA;
   localparam int CW     = $clog2(WARMUP);
   // Slot divisor: 1 + (2^31 - 2) / TABLE_SIZE.
   localparam logic [31:0] SLOT_DIV = 32'(1 + (2147483646 / TABLE_SIZE));

   localparam logic [1:0] ST_IDLE = 2'd0;
   localparam logic [1:0] ST_MUL  = 2'd1;
   localparam logic [1:0] ST_RED  = 2'd2;
   localparam logic [1:0] ST_OUT  = 2'd3;

   // sequencer and control
   logic [1:0]            state_ff, state_in;
   logic                  warm_ff, warm_in;      // warm-up steps still running
   logic                  seeded_ff, seeded_in;  // table loaded at least once
   logic [CW-1:0]         cnt_ff, cnt_in;        // warm-up steps left minus one

   // datapath
   word_type              lehmer_ff, lehmer_in;
   word_type              shuf_out_ff, shuf_out_in;
   logic [PROD_W-1:0]     prod_ff;
   logic [TABLE_SIZE-1:0] ge_ff;
   word_type              rd_ff;

   // response register
   logic                  rsp_valid_ff, rsp_valid_in;
   word_type              rsp_value_ff;
   word_type              rsp_seed_ff;

   // shuffle table
   word_type              shuf_mem [TABLE_SIZE];

   logic                  req_take;
   logic                  rsp_load;
   word_type              seed_w;
   word_type              seed_fix;
   logic [31:0]           fold_sum;
   word_type              red_value;
   logic [TABLE_SIZE-1:0] ge;
   logic [TABLE_SIZE-1:0] slot_hot;
   logic [SW-1:0]         slot;
   logic                  mem_we;
   logic [SW-1:0]         mem_wa;
   logic                  mem_re;

   assign req_tready = (state_ff == ST_IDLE);
   assign req_take   = req_tvalid & req_tready;
   assign rsp_load   = (state_ff == ST_OUT) & (~rsp_valid_ff | rsp_tready);

   // Map a zero seed, and the modulus itself, onto 1.
   assign seed_w   = req_tdata[WORD_W-1:0];
   assign seed_fix = (seed_w == '0 || seed_w == LEH_MOD) ? word_type'(1) : seed_w;

   // Fold the product: 2^31 == 1 mod (2^31 - 1), then one conditional subtract.
   assign fold_sum  = {1'b0, prod_ff[WORD_W-1:0]} + 32'(prod_ff[PROD_W-1:WORD_W]);
   assign red_value = (fold_sum >= {1'b0, LEH_MOD}) ?
                      WORD_W'(fold_sum - {1'b0, LEH_MOD}) : fold_sum[WORD_W-1:0];

   // Slot selection: thermometer of shuffle_out against k * SLOT_DIV.
   for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_thresh
      assign ge[k] = ({1'b0, shuf_out_ff} >= 32'(k) * SLOT_DIV);
   end

   for (genvar k = 0; k < TABLE_SIZE; k++) begin : g_hot
      if (k == TABLE_SIZE - 1) begin : g_top
         assign slot_hot[k] = ge_ff[k];
      end else begin : g_mid
         assign slot_hot[k] = ge_ff[k] & ~ge_ff[k+1];
      end
   end

   always_comb begin
      slot = '0;
      for (int k = 0; k < TABLE_SIZE; k++) begin
         if (slot_hot[k]) begin
            slot = slot | SW'(k);
         end
      end
   end

   // Table port control: warm-up fills the last TABLE_SIZE steps, a draw
   // reads the chosen slot and refills it in the same cycle.
   always_comb begin
      mem_we = 1'b0;
      mem_wa = slot;
      mem_re = 1'b0;
      if (state_ff == ST_RED) begin
         if (warm_ff) begin
            mem_we = (cnt_ff < CW'(TABLE_SIZE));
            mem_wa = cnt_ff[SW-1:0];
         end else begin
            mem_we = 1'b1;
            mem_re = 1'b1;
         end
      end
   end

   // Sequencer next state.
   always_comb begin
      state_in     = state_ff;
      warm_in      = warm_ff;
      seeded_in    = seeded_ff;
      cnt_in       = cnt_ff;
      lehmer_in    = lehmer_ff;
      shuf_out_in  = shuf_out_ff;
      rsp_valid_in = rsp_valid_ff & ~rsp_tready;
      case (state_ff)
         ST_IDLE: begin
            if (req_take) begin
               state_in = ST_MUL;
               if (req_tuser == CMD_RESEED || !seeded_ff) begin
                  warm_in   = 1'b1;
                  cnt_in    = CW'(WARMUP - 1);
                  lehmer_in = (req_tuser == CMD_RESEED) ? seed_fix : word_type'(1);
               end else begin
                  warm_in = 1'b0;
               end
            end
         end
         ST_MUL: begin
            state_in = ST_RED;
         end
         ST_RED: begin
            lehmer_in = red_value;
            if (warm_ff) begin
               state_in = ST_MUL;
               if (cnt_ff == '0) begin
                  // last warm-up step also lands in slot zero
                  warm_in     = 1'b0;
                  seeded_in   = 1'b1;
                  shuf_out_in = red_value;
               end else begin
                  cnt_in = cnt_ff - CW'(1);
               end
            end else begin
               state_in = ST_OUT;
            end
         end
         ST_OUT: begin
            if (rsp_load) begin
               state_in     = ST_IDLE;
               rsp_valid_in = 1'b1;
               shuf_out_in  = rd_ff;
            end
         end
         default: begin
            state_in = ST_IDLE;
         end
      endcase
   end

   always_ff @(posedge clock) begin
      if (reset) begin
         state_ff     <= ST_IDLE;
         warm_ff      <= 1'b0;
         seeded_ff    <= 1'b0;
         cnt_ff       <= '0;
         rsp_valid_ff <= 1'b0;
      end else begin
         state_ff     <= state_in;
         warm_ff      <= warm_in;
         seeded_ff    <= seeded_in;
         cnt_ff       <= cnt_in;
         rsp_valid_ff <= rsp_valid_in;
      end
   end

   // Payload registers: no reset, validity is tracked by the control state.
   always_ff @(posedge clock) begin
      lehmer_ff   <= lehmer_in;
      shuf_out_ff <= shuf_out_in;
      if (state_ff == ST_MUL) begin
         prod_ff <= PROD_W'(lehmer_ff) * PROD_W'(LEH_MUL);
         ge_ff   <= ge;
      end
      if (rsp_load) begin
         rsp_value_ff <= rd_ff;
         rsp_seed_ff  <= lehmer_ff;
      end
   end

   // Shuffle table: one write port, one registered read port (read-first).
   always_ff @(posedge clock) begin
      if (mem_re) begin
         rd_ff <= shuf_mem[slot];
      end
      if (mem_we) begin
         shuf_mem[mem_wa] <= red_value;
      end
   end

   assign rsp_tvalid = rsp_valid_ff;
   assign rsp_tdata  = {2'b00, rsp_seed_ff, rsp_value_ff};

   `include "shuffled_lehmer_uniform_generator_unit_macros.svh"

   `SLUG_ASSERT_NEXT(a_take_leaves_idle, req_take, state_ff == ST_MUL, "request taken but sequencer did not start")
   `SLUG_ASSERT_NOW(a_fold_in_range, state_ff == ST_RED, red_value != '0 && red_value != LEH_MOD, "generator step left the range 1..2^31-2")
   `SLUG_ASSERT_NOW(a_slot_onehot, state_ff == ST_RED && !warm_ff, $onehot(slot_hot), "slot thermometer is not monotonic")
   `SLUG_ASSERT_NOW(a_draw_after_seed, state_ff == ST_OUT, seeded_ff && !warm_ff, "draw finished before the table was loaded")
   `SLUG_ASSERT_NOW(a_rsp_nonzero, rsp_valid_ff, rsp_value_ff != '0 && rsp_seed_ff != '0, "response word carries a zero value")

endmodule
